// ===== rtl/n2r_pkg.sv =====
// Shared types, constants and helper functions for the nested-to-ring index converter.
`timescale 1ns / 1ps
`default_nettype none
package n2r_pkg;

  localparam int NEST_W    = 62;
  localparam int ORD_W     = 5;
  localparam int MAX_ORDER = 29;
  localparam int COORD_W   = MAX_ORDER;
  localparam int NSIDE_W   = COORD_W + 1;
  localparam int JR_W      = NSIDE_W + 1;
  localparam int JP_W      = NSIDE_W + 2;
  localparam int NUM_W     = JP_W + 2;
  localparam int PROD_W    = 2 * NSIDE_W;
  localparam int FACE_W    = 4;
  localparam int SHIFT_W   = 6;

  localparam logic [ORD_W-1:0] MAX_ORD = ORD_W'(MAX_ORDER);

  // after face split and de-interleave
  typedef struct packed {
    logic               oor;
    logic               last;
    logic [FACE_W-1:0]  face;
    logic [COORD_W-1:0] ix;
    logic [COORD_W-1:0] iy;
    logic [JR_W-1:0]    jr;
  } dec_t;

  // after ring region and phase
  typedef struct packed {
    logic               oor;
    logic               last;
    logic               north;
    logic               south;
    logic [NSIDE_W-1:0] mul_a;
    logic [NSIDE_W-1:0] mul_b;
    logic [NEST_W-1:0]  base;
    logic [JP_W-1:0]    jp;
  } loc_t;

  // after cap product
  typedef struct packed {
    logic              oor;
    logic              last;
    logic              north;
    logic              south;
    logic [PROD_W-1:0] prod;
    logic [NEST_W-1:0] base;
    logic [JP_W-1:0]   jp;
  } mul_t;

  function automatic logic [2:0] ring_base(input logic [FACE_W-1:0] face);
    logic [2:0] r;
    case (face) inside
      [4'd0:4'd3]:  r = 3'd2;
      [4'd4:4'd7]:  r = 3'd3;
      [4'd8:4'd11]: r = 3'd4;
      default:      r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] phase_base(input logic [FACE_W-1:0] face);
    logic [2:0] r;
    case (face) inside
      4'd0, 4'd8:  r = 3'd1;
      4'd1, 4'd9:  r = 3'd3;
      4'd2, 4'd10: r = 3'd5;
      4'd3, 4'd11: r = 3'd7;
      4'd5:        r = 3'd2;
      4'd6:        r = 3'd4;
      4'd7:        r = 3'd6;
      default:     r = 3'd0;
    endcase
    return r;
  endfunction

  // gather the even bits of v
  function automatic logic [COORD_W-1:0] compact(input logic [NEST_W-1:0] v);
    logic [COORD_W-1:0] r;
    for (int k = 0; k < COORD_W; k++) begin
      r[k] = v[2*k];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/n2r_decode.sv =====
// Face split, range check, sub-index de-interleave and ring number.
`timescale 1ns / 1ps
`default_nettype none
module n2r_decode (
  input  logic [n2r_pkg::ORD_W-1:0]  ord,
  input  logic [n2r_pkg::NEST_W-1:0] nest,
  input  logic                       last,
  output n2r_pkg::dec_t              dec
);

  localparam int NW = n2r_pkg::NEST_W;
  localparam int JW = n2r_pkg::JR_W;

  logic [n2r_pkg::SHIFT_W-1:0] sh;
  logic [NW-1:0]               face_full;
  logic [NW-1:0]               sub;
  logic [2:0]                  rb;
  logic [JW:0]                 rb_n;
  logic [JW:0]                 jr_w;
  logic [n2r_pkg::COORD_W-1:0] ix;
  logic [n2r_pkg::COORD_W-1:0] iy;

  always_comb begin
    sh        = {ord, 1'b0};
    face_full = nest >> sh;
    sub       = nest & ~({NW{1'b1}} << sh);
    ix        = n2r_pkg::compact(sub);
    iy        = n2r_pkg::compact(sub >> 1);
    rb        = n2r_pkg::ring_base(face_full[n2r_pkg::FACE_W-1:0]);
    rb_n      = (JW+1)'(rb) << ord;
    jr_w      = rb_n - (JW+1)'(ix) - (JW+1)'(iy) - (JW+1)'(1);

    dec.oor  = face_full >= NW'(12);
    dec.last = last;
    dec.face = face_full[n2r_pkg::FACE_W-1:0];
    dec.ix   = ix;
    dec.iy   = iy;
    dec.jr   = jr_w[JW-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/n2r_locate.sv =====
// Cap or belt selection, phase within the ring and operands for the cap product.
`timescale 1ns / 1ps
`default_nettype none
module n2r_locate (
  input  logic [n2r_pkg::ORD_W-1:0] ord,
  input  n2r_pkg::dec_t             dec,
  output n2r_pkg::loc_t             loc
);

  localparam int NW = n2r_pkg::NEST_W;
  localparam int SW = n2r_pkg::NSIDE_W;
  localparam int JW = n2r_pkg::JR_W;
  localparam int PW = n2r_pkg::JP_W;
  localparam int MW = n2r_pkg::NUM_W;
  localparam int HW = n2r_pkg::SHIFT_W;

  logic [SW-1:0] nside;
  logic [JW-1:0] nside_j;
  logic [JW-1:0] three_n;
  logic [PW-1:0] four_n;
  logic          north;
  logic          south;
  logic          belt;
  logic [PW-1:0] south_nr;
  logic [SW-1:0] nr;
  logic [JW-1:0] belt_off;
  logic          kshift;
  logic [PW-1:0] pb_nr;
  logic [MW-1:0] num;
  logic [MW-1:0] num_adj;
  logic [MW-1:0] half;
  logic [MW-1:0] jp_fix;
  logic [NW-1:0] eq_off;
  logic [NW-1:0] ncap;
  logic [NW-1:0] npix;

  always_comb begin
    nside    = SW'(1) << ord;
    nside_j  = JW'(nside);
    three_n  = nside_j + (nside_j << 1);
    four_n   = PW'(nside) << 2;
    north    = dec.jr < nside_j;
    south    = dec.jr > three_n;
    belt     = !north && !south;
    south_nr = four_n - PW'(dec.jr);
    if (north) begin
      nr = dec.jr[SW-1:0];
    end else if (south) begin
      nr = south_nr[SW-1:0];
    end else begin
      nr = nside;
    end
    belt_off = dec.jr - nside_j;
    kshift   = belt && belt_off[0];

    // phase, halved with truncation toward zero
    pb_nr   = PW'(n2r_pkg::phase_base(dec.face)) * PW'(nr);
    num     = MW'(pb_nr) + MW'(dec.ix) - MW'(dec.iy) + MW'(1) + MW'(kshift);
    num_adj = num + MW'(num[MW-1]);
    half    = {num_adj[MW-1], num_adj[MW-1:1]};
    if ($signed(half) > $signed(MW'(four_n))) begin
      jp_fix = half - MW'(four_n);
    end else if ($signed(half) < $signed(MW'(1))) begin
      jp_fix = half + MW'(four_n);
    end else begin
      jp_fix = half;
    end

    eq_off = NW'(belt_off) << (HW'(ord) + HW'(2));
    ncap   = (NW'(1) << {ord, 1'b1}) - (NW'(1) << (HW'(ord) + HW'(1)));
    npix   = NW'(3) << (HW'({ord, 1'b0}) + HW'(2));

    loc.oor   = dec.oor;
    loc.last  = dec.last;
    loc.north = north;
    loc.south = south;
    loc.mul_a = nr;
    loc.mul_b = south ? nr + SW'(1) : nr - SW'(1);
    if (south) begin
      loc.base = npix;
    end else if (belt) begin
      loc.base = ncap + eq_off;
    end else begin
      loc.base = '0;
    end
    loc.jp = jp_fix[PW-1:0];
  end

endmodule
`default_nettype wire

// ===== rtl/n2r_assemble.sv =====
// Pixels before the ring plus phase, with the out-of-range override.
`timescale 1ns / 1ps
`default_nettype none
module n2r_assemble (
  input  n2r_pkg::mul_t              mul,
  output logic [n2r_pkg::NEST_W-1:0] ring_index,
  output logic                       out_of_range,
  output logic                       last_out
);

  localparam int NW = n2r_pkg::NEST_W;

  logic [NW-1:0] prod2;
  logic [NW-1:0] prior;
  logic [NW-1:0] ring;

  always_comb begin
    prod2 = NW'(mul.prod) << 1;
    if (mul.north) begin
      prior = prod2;
    end else if (mul.south) begin
      prior = mul.base - prod2;
    end else begin
      prior = mul.base;
    end
    ring         = prior + NW'(mul.jp) - NW'(1);
    ring_index   = mul.oor ? '0 : ring;
    out_of_range = mul.oor;
    last_out     = mul.last;
  end

endmodule
`default_nettype wire

// ===== rtl/nested_to_ring_pixel_index_core.sv =====
// Top level: order register and the five-register conversion pipeline.
// An item passes the input, decode, locate, multiply and output registers in turn.
// Throughput: one item per cycle while out_ready is high; each stage holds under back-pressure and
// empty stages fill, so out_ready low stalls only as far back as needed.
// Reset (rst_n low, synchronous) empties the pipeline and sets order to 0.
// Stages: input, decode, locate, 30x30 cap multiply, assemble into output.
`timescale 1ns / 1ps
`default_nettype none
module nested_to_ring_pixel_index_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [n2r_pkg::ORD_W-1:0]   cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [n2r_pkg::NEST_W-1:0]  in_nest_index,
  input  logic                        in_last_in_batch,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [n2r_pkg::NEST_W-1:0]  out_ring_index,
  output logic                        out_out_of_range,
  output logic                        out_last_out
);

  logic [n2r_pkg::ORD_W-1:0]  order_r;
  logic [n2r_pkg::ORD_W-1:0]  ord;

  logic                       v0_r, v1_r, v2_r, v3_r, out_valid_r;
  logic                       rdy1, rdy2, rdy3, rdy_out;

  logic [n2r_pkg::NEST_W-1:0] nest_r;
  logic                       last_r;
  n2r_pkg::dec_t              s1_nxt, s1_r;
  n2r_pkg::loc_t              s2_nxt, s2_r;
  n2r_pkg::mul_t              s3_nxt, s3_r;

  logic [n2r_pkg::NEST_W-1:0] ring_nxt, ring_r;
  logic                       oor_nxt, oor_r;
  logic                       last_nxt, last_out_r;

  assign ord = (order_r > n2r_pkg::MAX_ORD) ? n2r_pkg::MAX_ORD : order_r;

  assign rdy_out  = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = !v0_r || rdy1;

  n2r_decode u_decode (
    .ord  (ord),
    .nest (nest_r),
    .last (last_r),
    .dec  (s1_nxt)
  );

  n2r_locate u_locate (
    .ord (ord),
    .dec (s1_r),
    .loc (s2_nxt)
  );

  always_comb begin
    s3_nxt.oor   = s2_r.oor;
    s3_nxt.last  = s2_r.last;
    s3_nxt.north = s2_r.north;
    s3_nxt.south = s2_r.south;
    s3_nxt.prod  = n2r_pkg::PROD_W'(s2_r.mul_a) * n2r_pkg::PROD_W'(s2_r.mul_b);
    s3_nxt.base  = s2_r.base;
    s3_nxt.jp    = s2_r.jp;
  end

  n2r_assemble u_assemble (
    .mul          (s3_r),
    .ring_index   (ring_nxt),
    .out_of_range (oor_nxt),
    .last_out     (last_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= '0;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
      if (in_ready) begin
        v0_r <= in_valid;
      end
      if (rdy1) begin
        v1_r <= v0_r;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      nest_r <= in_nest_index;
      last_r <= in_last_in_batch;
    end
    if (rdy1) begin
      s1_r <= s1_nxt;
    end
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
    if (rdy3) begin
      s3_r <= s3_nxt;
    end
    if (rdy_out) begin
      ring_r     <= ring_nxt;
      oor_r      <= oor_nxt;
      last_out_r <= last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ring_index   = ring_r;
  assign out_out_of_range = oor_r;
  assign out_last_out     = last_out_r;

endmodule
`default_nettype wire
